// ----- sv/lcdwf_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdwf_pkg
// Shared types, command codes and byte helpers for the LCD window fill
// rasterizer.
// ----------------------------------------------------------------------------
package lcdwf_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int COORD_MAX_BITS = 16;
	localparam int SCREEN_BITS    = 10;
	localparam int COLOR_BITS     = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int IDX_BITS       = 5;

	localparam logic [SCREEN_BITS-1:0] SCREEN_X_MAX_RST = 10'd239;
	localparam logic [SCREEN_BITS-1:0] SCREEN_Y_MAX_RST = 10'd319;
	localparam logic [COLOR_BITS-1:0]  FORE_COLOR_RST   = 16'hFFFF;
	localparam logic [COLOR_BITS-1:0]  BACK_COLOR_RST   = 16'h0000;

	localparam logic [7:0] CMD_COL  = 8'h2A;
	localparam logic [7:0] CMD_ROW  = 8'h2B;
	localparam logic [7:0] CMD_MEMW = 8'h2C;
	localparam logic       DC_DATA  = 1'b1;
	localparam logic       DC_CMD   = 1'b0;

	localparam logic [1:0] OP_RECT = 2'd0;
	localparam logic [1:0] OP_TRI  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FORE_COLOR   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BACK_COLOR   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_X_MAX = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_Y_MAX = 2'd3;

	localparam logic [IDX_BITS-1:0] WIN_LEN         = 5'd11;
	localparam logic [IDX_BITS-1:0] PIX_LEN         = 5'd2;
	localparam logic [IDX_BITS-1:0] END_WIN         = 5'd10;
	localparam logic [IDX_BITS-1:0] END_WIN_RESTORE = 5'd21;
	localparam logic [IDX_BITS-1:0] END_PIX         = 5'd1;
	localparam logic [IDX_BITS-1:0] END_PIX_RESTORE = 5'd12;

	localparam logic [3:0] WB_CMD_COL = 4'd0;
	localparam logic [3:0] WB_XA_HI   = 4'd1;
	localparam logic [3:0] WB_XA_LO   = 4'd2;
	localparam logic [3:0] WB_XB_HI   = 4'd3;
	localparam logic [3:0] WB_XB_LO   = 4'd4;
	localparam logic [3:0] WB_CMD_ROW = 4'd5;
	localparam logic [3:0] WB_YA_HI   = 4'd6;
	localparam logic [3:0] WB_YA_LO   = 4'd7;
	localparam logic [3:0] WB_YB_HI   = 4'd8;
	localparam logic [3:0] WB_YB_LO   = 4'd9;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_RECT = 3'b010,
		MODE_TRI  = 3'b100
	} mode_t;

	typedef struct packed {
		logic                      is_pix;
		logic [COLOR_BITS-1:0]     color;
		logic [COORD_MAX_BITS-1:0] xa;
		logic [COORD_MAX_BITS-1:0] ya;
		logic [COORD_MAX_BITS-1:0] xb;
		logic [COORD_MAX_BITS-1:0] yb;
		logic [IDX_BITS-1:0]       end_idx;
	} job_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_data;
	} out_byte_t;

	function automatic out_byte_t window_byte(
		input logic [3:0]                k,
		input logic [COORD_MAX_BITS-1:0] xa,
		input logic [COORD_MAX_BITS-1:0] ya,
		input logic [COORD_MAX_BITS-1:0] xb,
		input logic [COORD_MAX_BITS-1:0] yb
	);
		out_byte_t r;
		case (k)
			WB_CMD_COL: r = '{data: CMD_COL, is_data: DC_CMD};
			WB_XA_HI:   r = '{data: xa[15:8], is_data: DC_DATA};
			WB_XA_LO:   r = '{data: xa[7:0], is_data: DC_DATA};
			WB_XB_HI:   r = '{data: xb[15:8], is_data: DC_DATA};
			WB_XB_LO:   r = '{data: xb[7:0], is_data: DC_DATA};
			WB_CMD_ROW: r = '{data: CMD_ROW, is_data: DC_CMD};
			WB_YA_HI:   r = '{data: ya[15:8], is_data: DC_DATA};
			WB_YA_LO:   r = '{data: ya[7:0], is_data: DC_DATA};
			WB_YB_HI:   r = '{data: yb[15:8], is_data: DC_DATA};
			WB_YB_LO:   r = '{data: yb[7:0], is_data: DC_DATA};
			default:    r = '{data: CMD_MEMW, is_data: DC_CMD};
		endcase
		return r;
	endfunction

endpackage

// ----- sv/lcd_window_fill_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// lcd_window_fill_rasterizer_unit
// Turns rectangle, triangle and pixel tick commands into the command/data
// byte stream of an SPI TFT controller.
// ----------------------------------------------------------------------------
// An item passes the input register, the emitter job register and the output
// register. Throughput: one byte per cycle from the output register while m_tready
// is high. A tick sends its pixel colour, plus a full-screen window on the final
// pixel; a start sends its window, plus a full-screen window when fully clipped. The byte sequencer sets this rate.
// Reset clears the drawing state and loads the register defaults.
module lcd_window_fill_rasterizer_unit
	import lcdwf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// corner_a_x, corner_a_y, corner_b_x, corner_b_y, zero padding
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
	// operation
	input  logic [1:0]                              s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// out_byte
	output logic [7:0]                              m_tdata,
	// is_data
	output logic                                    m_tuser,
	output logic                                    m_tlast,
	input  logic                                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0]                 cfg_index,
	input  logic [CFG_DATA_BITS-1:0]                cfg_data
);

	localparam int C  = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;

	logic [COLOR_BITS-1:0]  fore_color_q;
	logic [COLOR_BITS-1:0]  back_color_q;
	logic [SCREEN_BITS-1:0] screen_x_max_q;
	logic [SCREEN_BITS-1:0] screen_y_max_q;

	logic         valid_s1;
	logic [1:0]   op_s1;
	logic [C-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	mode_t        mode_q, mode_d;
	logic [C-1:0] col_q, col_d;
	logic [C-1:0] row_q, row_d;
	logic [C-1:0] width_q, width_d;
	logic [C-1:0] height_q, height_d;
	logic [C-1:0] last_col_q, last_col_d;
	logic [C-1:0] last_row_q, last_row_d;

	logic         s1_adv;
	logic         job_free;
	logic         job_go;
	job_t         job_d;

	logic [C-1:0] x_lo, x_hi, y_lo, y_hi;
	logic [COORD_MAX_BITS-1:0] x_hi16, y_hi16, sx16, sy16, xc16, yc16;
	logic [C-1:0] xc, yc;
	logic         tri_vis;

	logic [C-1:0]  cx;
	logic [C-1:0]  col_dist;
	logic [C-1:0]  dy;
	logic [PW-1:0] pt;
	logic [PW-1:0] edge_full;
	logic          tri_fore;
	logic          row_end;
	logic          finish;
	logic [COLOR_BITS-1:0] pix_color;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_color_q   <= FORE_COLOR_RST;
			back_color_q   <= BACK_COLOR_RST;
			screen_x_max_q <= SCREEN_X_MAX_RST;
			screen_y_max_q <= SCREEN_Y_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORE_COLOR:   fore_color_q   <= cfg_data;
				CFG_BACK_COLOR:   back_color_q   <= cfg_data;
				CFG_SCREEN_X_MAX: screen_x_max_q <= cfg_data[SCREEN_BITS-1:0];
				CFG_SCREEN_Y_MAX: screen_y_max_q <= cfg_data[SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	assign s1_adv   = valid_s1 && job_free;
	assign s_tready = !valid_s1 || job_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			ax_s1 <= s_tdata[C-1:0];
			ay_s1 <= s_tdata[2*C-1:C];
			bx_s1 <= s_tdata[3*C-1:2*C];
			by_s1 <= s_tdata[4*C-1:3*C];
		end
	end

	// Corner sorting and clipping.
	assign x_lo = (ax_s1 > bx_s1) ? bx_s1 : ax_s1;
	assign x_hi = (ax_s1 > bx_s1) ? ax_s1 : bx_s1;
	assign y_lo = (ay_s1 > by_s1) ? by_s1 : ay_s1;
	assign y_hi = (ay_s1 > by_s1) ? ay_s1 : by_s1;

	assign x_hi16  = COORD_MAX_BITS'(x_hi);
	assign y_hi16  = COORD_MAX_BITS'(y_hi);
	assign sx16    = COORD_MAX_BITS'(screen_x_max_q);
	assign sy16    = COORD_MAX_BITS'(screen_y_max_q);
	assign xc16    = (x_hi16 > sx16) ? sx16 : x_hi16;
	assign yc16    = (y_hi16 > sy16) ? sy16 : y_hi16;
	assign xc      = xc16[C-1:0];
	assign yc      = yc16[C-1:0];
	assign tri_vis = (x_lo <= xc) && (y_lo <= yc);

	// Triangle inside test for the current pixel.
	assign cx        = width_q >> 1;
	assign col_dist  = (col_q >= cx) ? (col_q - cx) : (cx - col_q);
	assign dy        = (height_q >= row_q) ? (height_q - row_q) : '0;
	assign pt        = PW'(col_dist) * PW'(height_q);
	assign edge_full = PW'(width_q) * PW'(dy);
	assign tri_fore  = pt <= (edge_full >> 1);

	assign row_end   = col_q >= last_col_q;
	assign finish    = row_end && ((mode_q == MODE_TRI) ? (row_q == '0) : (row_q == last_row_q));
	assign pix_color = ((mode_q == MODE_TRI) && !tri_fore) ? back_color_q : fore_color_q;

	always_comb begin
		mode_d     = mode_q;
		col_d      = col_q;
		row_d      = row_q;
		width_d    = width_q;
		height_d   = height_q;
		last_col_d = last_col_q;
		last_row_d = last_row_q;
		job_go     = 1'b0;
		job_d      = '0;
		case (op_s1)
			OP_RECT: begin
				width_d       = x_hi - x_lo;
				height_d      = y_hi - y_lo;
				col_d         = '0;
				row_d         = '0;
				last_col_d    = x_hi - x_lo;
				last_row_d    = y_hi - y_lo;
				mode_d        = MODE_RECT;
				job_go        = 1'b1;
				job_d.xa      = COORD_MAX_BITS'(x_lo);
				job_d.ya      = COORD_MAX_BITS'(y_lo);
				job_d.xb      = COORD_MAX_BITS'(x_hi);
				job_d.yb      = COORD_MAX_BITS'(y_hi);
				job_d.end_idx = END_WIN;
			end
			OP_TRI: begin
				width_d  = x_hi - x_lo;
				height_d = y_hi - y_lo;
				col_d    = '0;
				job_go   = 1'b1;
				job_d.xa = COORD_MAX_BITS'(x_lo);
				job_d.ya = COORD_MAX_BITS'(y_lo);
				job_d.xb = xc16;
				job_d.yb = yc16;
				if (tri_vis) begin
					last_col_d    = xc - x_lo;
					last_row_d    = yc - y_lo;
					row_d         = yc - y_lo;
					mode_d        = MODE_TRI;
					job_d.end_idx = END_WIN;
				end else begin
					last_col_d    = '0;
					last_row_d    = '0;
					row_d         = '0;
					mode_d        = MODE_IDLE;
					job_d.end_idx = END_WIN_RESTORE;
				end
			end
			OP_TICK: begin
				if (mode_q != MODE_IDLE) begin
					job_go        = 1'b1;
					job_d.is_pix  = 1'b1;
					job_d.color   = pix_color;
					job_d.end_idx = finish ? END_PIX_RESTORE : END_PIX;
					if (finish) begin
						mode_d = MODE_IDLE;
						col_d  = '0;
						row_d  = '0;
					end else if (row_end) begin
						col_d = '0;
						if (mode_q == MODE_TRI) begin
							row_d = row_q - 1'b1;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
			last_col_q <= '0;
			last_row_q <= '0;
		end else if (s1_adv) begin
			mode_q     <= mode_d;
			col_q      <= col_d;
			row_q      <= row_d;
			width_q    <= width_d;
			height_q   <= height_d;
			last_col_q <= last_col_d;
			last_row_q <= last_row_d;
		end
	end

	lcdwf_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_load     (s1_adv && job_go),
		.job_in       (job_d),
		.job_free     (job_free),
		.screen_x_max (screen_x_max_q),
		.screen_y_max (screen_y_max_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

	a_idle_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (col_q == '0 && row_q == '0))
		else $error("Idle state holds a nonzero pixel position.");

	a_col_range : assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (col_q <= last_col_q))
		else $error("Column position passed the last visible column.");

	a_tri_row_range : assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_TRI) |-> (row_q <= last_row_q))
		else $error("Triangle row position passed the last visible row.");

	a_last_cmd : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && !m_tuser) |-> (m_tdata == CMD_MEMW))
		else $error("A command byte closing a transaction run is not memory write.");

endmodule

// ----- sv/lcdwf_emitter.sv -----
// ----------------------------------------------------------------------------
// lcdwf_emitter
// Holds one byte job and plays it out, one byte per cycle while m_tready is high, into a registered
// stream output.
// ----------------------------------------------------------------------------
module lcdwf_emitter
	import lcdwf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_load,
	input  job_t                   job_in,
	output logic                   job_free,
	input  logic [SCREEN_BITS-1:0] screen_x_max,
	input  logic [SCREEN_BITS-1:0] screen_y_max,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,  // out_byte
	output logic                   m_tuser,  // is_data
	output logic                   m_tlast
);

	job_t                     job_q;
	logic                     job_v_q;
	logic [IDX_BITS-1:0]      idx_q;
	logic                     step;
	logic                     done;
	logic [COORD_MAX_BITS-1:0] rx;
	logic [COORD_MAX_BITS-1:0] ry;
	logic [IDX_BITS-1:0]      pix_off;
	logic [IDX_BITS-1:0]      win_off;
	out_byte_t                sel;

	assign step     = job_v_q && (!m_tvalid || m_tready);
	assign done     = step && (idx_q == job_q.end_idx);
	assign job_free = !job_v_q || done;

	assign rx      = COORD_MAX_BITS'(screen_x_max);
	assign ry      = COORD_MAX_BITS'(screen_y_max);
	assign pix_off = idx_q - PIX_LEN;
	assign win_off = idx_q - WIN_LEN;

	always_comb begin
		if (job_q.is_pix) begin
			if (idx_q < PIX_LEN) begin
				sel.data    = idx_q[0] ? job_q.color[7:0] : job_q.color[15:8];
				sel.is_data = DC_DATA;
			end else begin
				sel = window_byte(pix_off[3:0], '0, '0, rx, ry);
			end
		end else begin
			if (idx_q < WIN_LEN) begin
				sel = window_byte(idx_q[3:0], job_q.xa, job_q.ya, job_q.xb, job_q.yb);
			end else begin
				sel = window_byte(win_off[3:0], '0, '0, rx, ry);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (job_load) begin
			job_v_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			job_v_q <= 1'b0;
		end else if (step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (step) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= sel.data;
			m_tuser <= sel.is_data;
			m_tlast <= (idx_q == job_q.end_idx);
		end
	end

endmodule
